[rtl/vtc_pkg.sv]
`default_nettype none

package vtc_pkg;

    typedef logic [1:0]  status_t;
    typedef logic [31:0] word_t;
    typedef logic [7:0]  byte_t;

    localparam status_t ST_OK            = 2'd0;
    localparam status_t ST_NO_MAJORITY   = 2'd1;
    localparam status_t ST_NO_CHECKPOINT = 2'd2;
    localparam status_t ST_MISMATCH      = 2'd3;

    localparam logic CMD_SAVE   = 1'b0;
    localparam logic CMD_VERIFY = 1'b1;

    localparam word_t CRC_POLY   = 32'hEDB8_8320;
    localparam word_t ALL_ONES   = 32'hFFFF_FFFF;
    localparam int    HASH_SHIFT = 5;

    // Reflected CRC-32, one byte, unrolled bit by bit
    function automatic word_t crc_byte(input word_t c_in, input byte_t b);
        word_t c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/vtc_in_if.sv]
`default_nettype none

interface vtc_in_if
    import vtc_pkg::*;
();
    logic  valid;
    logic  ready;
    logic  cmd;
    byte_t data_byte;
    logic  has_byte;
    logic  last;

    modport source (output valid, output cmd, output data_byte, output has_byte,
                    output last, input ready);
    modport sink   (input valid, input cmd, input data_byte, input has_byte,
                    input last, output ready);
endinterface

`default_nettype wire

[rtl/vtc_out_if.sv]
`default_nettype none

interface vtc_out_if
    import vtc_pkg::*;
();
    logic    valid;
    logic    ready;
    status_t status;
    word_t   voted_checksum;

    modport source (output valid, output status, output voted_checksum, input ready);
    modport sink   (input valid, input status, input voted_checksum, output ready);
endinterface

`default_nettype wire

[rtl/voted_triple_checksum_checkpoint.sv]
`default_nettype none

// Voted triple checksum checkpoint. Takes one byte item per clock with no
// bubbles unless a waiting result stalls it; unstalled, the sustained rate is
// one item per cycle. An item is captured in an input register and its byte, if
// any, is folded into the byte sum, the times-31 hash and the reflected CRC-32
// (eight unrolled bit steps) as the item leaves that register. On the item
// flagged last the three values are 2-of-3 voted and the save/verify outcome
// lands in the result register as it leaves. A waiting result only stalls the
// stream when the next last item reaches the input register; non-last items
// keep flowing. The checkpoint survives messages and only reset clears it.
module voted_triple_checksum_checkpoint
    import vtc_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    vtc_in_if.sink     msg,
    vtc_out_if.source  res
);

    // input register
    logic    s1_valid_reg;
    logic    s1_cmd_reg;
    byte_t   s1_byte_reg;
    logic    s1_has_reg;
    logic    s1_last_reg;

    // accumulators and checkpoint
    word_t   byte_sum_reg,  byte_sum_next;
    word_t   hash31_reg,    hash31_next;
    word_t   crc_acc_reg,   crc_acc_next;
    word_t   saved_reg;
    logic    saved_valid_reg;

    // result register
    logic    res_valid_reg;
    status_t res_status_reg, res_status_next;
    word_t   res_value_reg,  res_value_next;

    logic    s1_adv;
    logic    res_load;
    logic    majority;
    word_t   winner;
    word_t   crc_final;
    logic    save_ok;

    assign s1_adv    = s1_valid_reg && (!s1_last_reg || !res_valid_reg || res.ready);
    assign msg.ready = !s1_valid_reg || s1_adv;
    assign res_load  = s1_adv && s1_last_reg;

    always_comb
    begin
        byte_sum_next = byte_sum_reg;
        hash31_next   = hash31_reg;
        crc_acc_next  = crc_acc_reg;
        if (s1_has_reg)
        begin
            byte_sum_next = byte_sum_reg + {24'd0, s1_byte_reg};
            hash31_next   = (hash31_reg << HASH_SHIFT) - hash31_reg + {24'd0, s1_byte_reg};
            crc_acc_next  = crc_byte(crc_acc_reg, s1_byte_reg);
        end
    end

    assign crc_final = crc_acc_next ^ ALL_ONES;

    // sum wins ties, then hash
    always_comb
    begin
        majority = 1'b1;
        winner   = byte_sum_next;
        if (byte_sum_next == hash31_next || byte_sum_next == crc_final)
        begin
            winner = byte_sum_next;
        end
        else if (hash31_next == crc_final)
        begin
            winner = hash31_next;
        end
        else
        begin
            majority = 1'b0;
            winner   = '0;
        end
    end

    always_comb
    begin
        res_status_next = ST_OK;
        res_value_next  = '0;
        save_ok         = 1'b0;
        case (s1_cmd_reg)
            CMD_SAVE:
            begin
                if (majority)
                begin
                    save_ok        = 1'b1;
                    res_value_next = winner;
                end
                else
                begin
                    res_status_next = ST_NO_MAJORITY;
                end
            end
            default:
            begin
                if (!saved_valid_reg)
                begin
                    res_status_next = ST_NO_CHECKPOINT;
                end
                else if (!majority)
                begin
                    res_status_next = ST_NO_MAJORITY;
                end
                else
                begin
                    res_value_next  = winner;
                    res_status_next = (winner == saved_reg) ? ST_OK : ST_MISMATCH;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (msg.ready)
        begin
            s1_valid_reg <= msg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (msg.ready && msg.valid)
        begin
            s1_cmd_reg  <= msg.cmd;
            s1_byte_reg <= msg.data_byte;
            s1_has_reg  <= msg.has_byte;
            s1_last_reg <= msg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_sum_reg    <= '0;
            hash31_reg      <= '0;
            crc_acc_reg     <= ALL_ONES;
            saved_reg       <= '0;
            saved_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            if (s1_last_reg)
            begin
                byte_sum_reg <= '0;
                hash31_reg   <= '0;
                crc_acc_reg  <= ALL_ONES;
                if (save_ok)
                begin
                    saved_reg       <= winner;
                    saved_valid_reg <= 1'b1;
                end
            end
            else
            begin
                byte_sum_reg <= byte_sum_next;
                hash31_reg   <= hash31_next;
                crc_acc_reg  <= crc_acc_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_status_reg <= res_status_next;
            res_value_reg  <= res_value_next;
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.status         = res_status_reg;
    assign res.voted_checksum = res_value_reg;

    // once a checkpoint is held it stays held
    a_saved_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        saved_valid_reg |=> saved_valid_reg)
        else $error("checkpoint valid dropped");

    a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> (byte_sum_reg == '0 && hash31_reg == '0 && crc_acc_reg == ALL_ONES))
        else $error("accumulators not cleared after message end");

    a_no_ckpt: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && res_status_next == ST_NO_CHECKPOINT) |-> !saved_valid_reg)
        else $error("no-checkpoint status with checkpoint held");

    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (res_status_reg == ST_NO_MAJORITY ||
                           res_status_reg == ST_NO_CHECKPOINT))
        |-> res_value_reg == '0)
        else $error("nonzero checksum with failing status");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res.ready) |-> !res_load)
        else $error("result overwritten while waiting");

endmodule

`default_nettype wire
